[src/mkd_pkg.sv]
`default_nettype none

package mkd_pkg;

  // Code register width; the leading 1 falls off the top on long characters
  localparam int CODE_BITS = 8;

  // Most results one sample can cause, and result queue depth
  localparam int MAX_EV      = 3;
  localparam int EVQ_DEPTH   = 4;
  localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
  localparam int EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);

  localparam int TICK_W = 16;
  localparam int CNT_W  = 8;

  typedef logic [CODE_BITS-1:0] code_t;
  localparam code_t CODE_ONE = code_t'(1);

  // Event kinds
  typedef enum logic [1:0] {
    EV_DOT  = 2'd0,
    EV_DASH = 2'd1,
    EV_CHAR = 2'd2,
    EV_WORD = 2'd3
  } ev_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DOT_MAX   = 2'd0,
    REG_CHAR_GAP  = 2'd1,
    REG_WORD_GAP  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] dot_max;
    logic [TICK_W-1:0] char_gap;
    logic [TICK_W-1:0] word_gap;
  } cfg_t;

  typedef struct packed {
    ev_kind_t         kind;
    logic [7:0]       code;
    logic [CNT_W-1:0] marks;
    logic [CNT_W-1:0] chars;
  } ev_t;

  // Events produced by one sample, slot 0 first
  typedef struct packed {
    logic [1:0]         n;
    ev_t [MAX_EV-1:0]   ev;
  } push_t;

  typedef struct packed {
    ev_t  ev;
    logic last;
  } qent_t;

endpackage

`default_nettype wire

[src/mkd_cfg.sv]
`default_nettype none

module mkd_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output mkd_pkg::cfg_t          cfg
);

  // Writes are always accepted: cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_max  <= 16'd2;
      cfg.char_gap <= 16'd10;
      cfg.word_gap <= 16'd20;
    end else if (cfg_valid && cfg_ready) begin
      case (mkd_pkg::reg_idx_t'(cfg_index))
        mkd_pkg::REG_DOT_MAX:  cfg.dot_max  <= cfg_data;
        mkd_pkg::REG_CHAR_GAP: cfg.char_gap <= cfg_data;
        mkd_pkg::REG_WORD_GAP: cfg.word_gap <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/mkd_core.sv]
`default_nettype none

module mkd_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          dot_key,
  input  wire logic          dash_key,
  input  wire logic          submit_key,
  input  wire logic          one_key_mode,
  input  wire logic          tick,
  input  wire mkd_pkg::cfg_t cfg,
  input  wire logic          room,
  output mkd_pkg::push_t     push
);

  typedef struct packed {
    mkd_pkg::code_t                code;
    logic [1:0]                    srun;
    logic [mkd_pkg::CNT_W-1:0]     marks;
    logic [mkd_pkg::CNT_W-1:0]     chars;
  } st_t;

  // Mark: count, shift in the bit, reopen the submit run
  function automatic st_t add_mark(st_t s, logic dash);
    st_t r;
    r = s;
    if (s.marks != '1) r.marks = s.marks + 1'b1;
    r.code = {s.code[mkd_pkg::CODE_BITS-2:0], dash};
    r.srun = 2'd0;
    return r;
  endfunction

  // Submit: clear the character, advance the saturating submit run
  function automatic st_t submit(st_t s);
    st_t r;
    r = s;
    r.marks = '0;
    if (s.srun != 2'd3) r.srun = s.srun + 2'd1;
    if (r.srun == 2'd1) r.chars = s.chars + 1'b1;
    r.code = mkd_pkg::CODE_ONE;
    return r;
  endfunction

  function automatic mkd_pkg::ev_t make_ev(mkd_pkg::ev_kind_t k, mkd_pkg::code_t c, st_t s);
    mkd_pkg::ev_t e;
    e.kind  = k;
    e.code  = 8'(c);
    e.marks = s.marks;
    e.chars = s.chars;
    return e;
  endfunction

  // Input register
  logic in_full;
  logic in_dot, in_dash, in_sub, in_one_key, in_tick;
  logic advance, accept;

  // Decoder state
  st_t st, st_next;
  logic [2:0] prev_keys, prev_keys_next;
  logic [mkd_pkg::TICK_W-1:0] hold_ticks, hold_ticks_next;
  logic [mkd_pkg::TICK_W-1:0] release_ticks, release_ticks_next;

  logic [2:0] now, rise;
  logic [1:0] cnt;
  mkd_pkg::ev_t [mkd_pkg::MAX_EV-1:0] evs;
  mkd_pkg::code_t sub_code;

  assign advance  = in_full && room;
  assign in_stall = in_full && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_dot     <= dot_key;
      in_dash    <= dash_key;
      in_sub     <= submit_key;
      in_one_key <= one_key_mode;
      in_tick    <= tick;
    end
  end

  // Event generation for the registered sample
  always_comb begin
    st_next            = st;
    prev_keys_next     = prev_keys;
    hold_ticks_next    = hold_ticks;
    release_ticks_next = release_ticks;
    cnt                = 2'd0;
    evs                = '0;
    sub_code           = st.code;
    now                = {in_sub, in_dash, in_dot};
    rise               = now & ~prev_keys;

    if (!in_one_key) begin
      if (rise[0]) begin
        st_next   = add_mark(st_next, 1'b0);
        evs[cnt]  = make_ev(mkd_pkg::EV_DOT, st_next.code, st_next);
        cnt       = cnt + 2'd1;
      end
      if (rise[1]) begin
        st_next   = add_mark(st_next, 1'b1);
        evs[cnt]  = make_ev(mkd_pkg::EV_DASH, st_next.code, st_next);
        cnt       = cnt + 2'd1;
      end
      if (rise[2]) begin
        sub_code = st_next.code;
        st_next  = submit(st_next);
        if (st_next.srun == 2'd1) begin
          evs[cnt] = make_ev(mkd_pkg::EV_CHAR, sub_code, st_next);
          cnt      = cnt + 2'd1;
        end else if (st_next.srun == 2'd2) begin
          evs[cnt] = make_ev(mkd_pkg::EV_WORD, sub_code, st_next);
          cnt      = cnt + 2'd1;
        end
      end
      prev_keys_next = now;
    end else begin
      // Release of the single key: hold length picks dot or dash
      if (!in_dot && prev_keys[0]) begin
        if (hold_ticks > cfg.dot_max) begin
          st_next  = add_mark(st_next, 1'b1);
          evs[cnt] = make_ev(mkd_pkg::EV_DASH, st_next.code, st_next);
        end else begin
          st_next  = add_mark(st_next, 1'b0);
          evs[cnt] = make_ev(mkd_pkg::EV_DOT, st_next.code, st_next);
        end
        cnt = cnt + 2'd1;
      end
      if (release_ticks > cfg.char_gap && st_next.srun == 2'd0) begin
        sub_code = st_next.code;
        st_next  = submit(st_next);
        evs[cnt] = make_ev(mkd_pkg::EV_CHAR, sub_code, st_next);
        cnt      = cnt + 2'd1;
      end
      if (release_ticks > cfg.word_gap && st_next.srun == 2'd1) begin
        sub_code = st_next.code;
        st_next  = submit(st_next);
        evs[cnt] = make_ev(mkd_pkg::EV_WORD, sub_code, st_next);
        cnt      = cnt + 2'd1;
      end
      prev_keys_next = {prev_keys[2:1], in_dot};
    end

    // Tick counters update after key handling
    if (in_tick) begin
      if (!in_one_key) begin
        hold_ticks_next    = '0;
        release_ticks_next = '0;
      end else if (!in_dot) begin
        hold_ticks_next = '0;
        if (release_ticks != '1) release_ticks_next = release_ticks + 1'b1;
      end else begin
        release_ticks_next = '0;
        if (hold_ticks != '1) hold_ticks_next = hold_ticks + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.code       <= mkd_pkg::CODE_ONE;
      st.srun       <= 2'd2;
      st.marks      <= '0;
      st.chars      <= '0;
      prev_keys     <= 3'b111;
      hold_ticks    <= '0;
      release_ticks <= '0;
    end else if (advance) begin
      st            <= st_next;
      prev_keys     <= prev_keys_next;
      hold_ticks    <= hold_ticks_next;
      release_ticks <= release_ticks_next;
    end
  end

  assign push.n  = advance ? cnt : 2'd0;
  assign push.ev = evs;

  // A held sample stays in the input register
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_full && !room |=> in_full)
    else $error("sample dropped while queue full");

  // Submit always returns the code register to the sentinel
  a_submit_code: assert property (@(posedge clk) disable iff (rst)
    advance && push.n != 2'd0 &&
    (push.ev[0].kind == mkd_pkg::EV_CHAR || push.ev[0].kind == mkd_pkg::EV_WORD)
    |=> st.code == mkd_pkg::CODE_ONE)
    else $error("code register not reset after submit");

endmodule

`default_nettype wire

[src/mkd_evq.sv]
`default_nettype none

module mkd_evq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mkd_pkg::push_t push,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         event_kind,
  output logic [7:0]         code_word,
  output logic [7:0]         mark_count,
  output logic [7:0]         char_count,
  output logic               last_event
);

  mkd_pkg::qent_t mem [mkd_pkg::EVQ_DEPTH];

  logic [mkd_pkg::EVQ_PTR_W-1:0] wptr, rptr;
  logic [mkd_pkg::EVQ_CNT_W-1:0] count;
  logic pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = count <= mkd_pkg::EVQ_CNT_W'(mkd_pkg::EVQ_DEPTH - mkd_pkg::MAX_EV);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + mkd_pkg::EVQ_PTR_W'(push.n);
      rptr  <= rptr + mkd_pkg::EVQ_PTR_W'(pop);
      count <= count + mkd_pkg::EVQ_CNT_W'(push.n) - mkd_pkg::EVQ_CNT_W'(pop);
    end
  end

  // Up to three entries written per transfer, last one flagged
  always_ff @(posedge clk) begin
    for (int i = 0; i < mkd_pkg::MAX_EV; i++) begin
      if (2'(i) < push.n) begin
        mem[wptr + mkd_pkg::EVQ_PTR_W'(i)].ev   <= push.ev[i];
        mem[wptr + mkd_pkg::EVQ_PTR_W'(i)].last <= (2'(i) == push.n - 2'd1);
      end
    end
  end

  assign event_kind = mem[rptr].ev.kind;
  assign code_word  = mem[rptr].ev.code;
  assign mark_count = mem[rptr].ev.marks;
  assign char_count = mem[rptr].ev.chars;
  assign last_event = mem[rptr].last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= mkd_pkg::EVQ_CNT_W'(mkd_pkg::EVQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst && pop |=> count == $past(count) + mkd_pkg::EVQ_CNT_W'($past(push.n)) - 1'b1)
    else $error("fill level mismatch");

endmodule

`default_nettype wire

[src/morse_key_input_decoder_unit.sv]
// Morse key input decoder.
// Input channel (in_valid / in_stall): one button sample per transfer with
// dot_key, dash_key, submit_key, one_key_mode and tick. Output channel
// (out_valid / out_stall): one event per transfer, event_kind, code_word,
// mark_count, char_count; last_event marks the final event of a sample.
// A sample yields zero to three events; a sample with none yields nothing.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): registers
// 0 dot_max_ticks, 1 char_gap_ticks, 2 word_gap_ticks; cfg_ready is always
// high, higher indexes are ignored. Write only while the block is idle.
// A sample lands in the input register at its transfer; its events are
// written into the four-entry result queue once the queue has room, and
// the head of the queue is offered on the output channel.
// Throughput: one sample per cycle while samples give at most one event
// and out_stall is low; the output port moves one event per cycle while
// out_stall is low, so samples with several events are paced by the
// queue, which takes a sample only with room for three events.
// Reset clears decoder state, queue and input register; config registers
// return to 2, 10 and 20. While out_stall is high the head event holds; once
// two or more events wait, a sample held in the input register raises in_stall.
`default_nettype none

module morse_key_input_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        dot_key,
  input  wire logic        dash_key,
  input  wire logic        submit_key,
  input  wire logic        one_key_mode,
  input  wire logic        tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_kind,
  output logic [7:0]       code_word,
  output logic [7:0]       mark_count,
  output logic [7:0]       char_count,
  output logic             last_event,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  mkd_pkg::cfg_t  cfg;
  mkd_pkg::push_t push;
  logic           room;

  mkd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mkd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .dot_key      (dot_key),
    .dash_key     (dash_key),
    .submit_key   (submit_key),
    .one_key_mode (one_key_mode),
    .tick         (tick),
    .cfg          (cfg),
    .room         (room),
    .push         (push)
  );

  mkd_evq u_evq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .code_word  (code_word),
    .mark_count (mark_count),
    .char_count (char_count),
    .last_event (last_event)
  );

endmodule

`default_nettype wire

[tb/tb_morse_key_input_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_morse_key_input_decoder_unit;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;

  // One button sample as driven on the input channel
  typedef struct packed {
    logic dot;
    logic dash;
    logic sub;
    logic one_key;
    logic tk;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        dot_key = 1'b0, dash_key = 1'b0, submit_key = 1'b0;
  logic        one_key_mode = 1'b0, tick = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  code_word, mark_count, char_count;
  logic        last_event;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  // Decoder state as the testbench predicts it
  mkd_pkg::cfg_t  key_cfg;
  mkd_pkg::code_t code_acc;
  logic [1:0]  submit_streak;
  logic [7:0]  mark_total, char_total;
  logic [2:0]  last_keys;
  logic [15:0] held_ticks, idle_ticks;

  mkd_pkg::qent_t expected_events[$];
  mkd_pkg::qent_t head_event;
  sample_t     pending_samples[$];
  sample_t     cur_sample;
  int          samples_queued = 0, samples_taken = 0;
  int          fail_count = 0, cycle_count = 0;
  int          in_gap = 0, in_calm = 0, stall_left = 0, out_calm = 0;
  logic        in_taken = 1'b0;

  morse_key_input_decoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .dot_key(dot_key), .dash_key(dash_key), .submit_key(submit_key),
    .one_key_mode(one_key_mode), .tick(tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .code_word(code_word), .mark_count(mark_count),
    .char_count(char_count), .last_event(last_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // ---------------- predictor ----------------

  task automatic push_event(input mkd_pkg::ev_kind_t kind, input mkd_pkg::code_t code,
                            inout int n);
    mkd_pkg::qent_t e;
    e.ev.kind  = kind;
    e.ev.code  = code[7:0];
    e.ev.marks = mark_total;
    e.ev.chars = char_total;
    e.last     = 1'b0;
    expected_events.push_back(e);
    n++;
  endtask

  task automatic key_mark(input logic is_dash, inout int n);
    if (mark_total != 8'hFF) mark_total++;
    code_acc      = {code_acc[mkd_pkg::CODE_BITS-2:0], is_dash};
    submit_streak = 2'd0;
    push_event(is_dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT, code_acc, n);
  endtask

  // First submit closes the character, second one is a word gap, more are silent
  task automatic close_char(inout int n);
    mkd_pkg::code_t sent;
    sent       = code_acc;
    mark_total = 8'd0;
    if (submit_streak != 2'd3) submit_streak++;
    if (submit_streak == 2'd1) begin
      char_total++;
      push_event(mkd_pkg::EV_CHAR, sent, n);
    end else if (submit_streak == 2'd2) begin
      push_event(mkd_pkg::EV_WORD, sent, n);
    end
    code_acc = mkd_pkg::CODE_ONE;
  endtask

  task automatic decode_sample(input sample_t s);
    int n;
    logic [2:0] now, rise;
    mkd_pkg::qent_t e;
    n = 0;
    if (!s.one_key) begin
      // three-button mode: rising edges, dot then dash then submit
      now  = {s.sub, s.dash, s.dot};
      rise = now & ~last_keys;
      if (rise[0]) key_mark(1'b0, n);
      if (rise[1]) key_mark(1'b1, n);
      if (rise[2]) close_char(n);
      last_keys = now;
    end else begin
      // one-key mode: release picks the mark, gaps use counts from before the sample
      if (!s.dot && last_keys[0]) key_mark(held_ticks > key_cfg.dot_max, n);
      if (idle_ticks > key_cfg.char_gap && submit_streak == 2'd0) close_char(n);
      if (idle_ticks > key_cfg.word_gap && submit_streak == 2'd1) close_char(n);
      last_keys[0] = s.dot;
    end
    if (s.tk) begin
      if (!s.one_key) begin
        held_ticks = 16'd0;
        idle_ticks = 16'd0;
      end else if (!s.dot) begin
        held_ticks = 16'd0;
        if (idle_ticks != 16'hFFFF) idle_ticks++;
      end else begin
        idle_ticks = 16'd0;
        if (held_ticks != 16'hFFFF) held_ticks++;
      end
    end
    if (n > 0) begin
      e = expected_events.pop_back();
      e.last = 1'b1;
      expected_events.push_back(e);
    end
  endtask

  // ---------------- driver and monitor ----------------

  // Input driver: next sample after a transfer, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        cur_sample = pending_samples.pop_front();
        dot_key      <= cur_sample.dot;
        dash_key     <= cur_sample.dash;
        submit_key   <= cur_sample.sub;
        one_key_mode <= cur_sample.one_key;
        tick         <= cur_sample.tk;
        in_valid     <= 1'b1;
        in_gap = pick_idle(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_idle(out_calm);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        samples_taken++;
        decode_sample({dot_key, dash_key, submit_key, one_key_mode, tick});
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event kind %0d with no event expected", event_kind));
        end else begin
          head_event = expected_events.pop_front();
          if (event_kind !== head_event.ev.kind)
            report_mismatch($sformatf("event_kind got %0d expected %0d",
                                      event_kind, head_event.ev.kind));
          if (code_word !== head_event.ev.code)
            report_mismatch($sformatf("code_word got %0h expected %0h",
                                      code_word, head_event.ev.code));
          if (mark_count !== head_event.ev.marks)
            report_mismatch($sformatf("mark_count got %0d expected %0d",
                                      mark_count, head_event.ev.marks));
          if (char_count !== head_event.ev.chars)
            report_mismatch($sformatf("char_count got %0d expected %0d",
                                      char_count, head_event.ev.chars));
          if (last_event !== head_event.last)
            report_mismatch($sformatf("last_event got %0b expected %0b",
                                      last_event, head_event.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("morse_key_input_decoder_unit regression: fail");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic queue_sample(input logic d, ds, s, okm, tk);
    pending_samples.push_back({d, ds, s, okm, tk});
    samples_queued++;
  endtask

  function automatic logic coin(input int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (samples_taken != samples_queued || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input mkd_pkg::reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mkd_pkg::REG_DOT_MAX:  key_cfg.dot_max  = val;
      mkd_pkg::REG_CHAR_GAP: key_cfg.char_gap = val;
      mkd_pkg::REG_WORD_GAP: key_cfg.word_gap = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] dmax, cgap, wgap);
    write_reg(mkd_pkg::REG_DOT_MAX, dmax);
    write_reg(mkd_pkg::REG_CHAR_GAP, cgap);
    write_reg(mkd_pkg::REG_WORD_GAP, wgap);
  endtask

  // Mostly well-formed key sequences with random content, some noise
  task automatic random_traffic(input int count);
    int stop_at, r, hold_len, rel_len, span, i;
    logic [2:0] keys;
    stop_at = samples_queued + count;
    while (samples_queued < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        // three-button press then release
        keys     = 3'($urandom_range(1, 7));
        hold_len = $urandom_range(1, 3);
        rel_len  = $urandom_range(1, 2);
        for (i = 0; i < hold_len; i++)
          queue_sample(keys[0], keys[1], keys[2], 1'b0, coin(50));
        for (i = 0; i < rel_len; i++)
          queue_sample(1'b0, 1'b0, 1'b0, 1'b0, coin(50));
      end else if (r < 8) begin
        // one-key hold then release gap
        span     = (key_cfg.word_gap > 26) ? 30 : int'(key_cfg.word_gap) + 4;
        hold_len = $urandom_range(1, 6);
        rel_len  = $urandom_range(1, span);
        for (i = 0; i < hold_len; i++)
          queue_sample(1'b1, coin(50), coin(50), 1'b1, coin(70));
        for (i = 0; i < rel_len; i++)
          queue_sample(1'b0, coin(50), coin(50), 1'b1, coin(85));
      end else begin
        hold_len = $urandom_range(1, 4);
        for (i = 0; i < hold_len; i++)
          queue_sample(coin(50), coin(50), coin(50), coin(50), coin(50));
      end
    end
  endtask

  // Marks without a submit, by alternating modes, until the mark count saturates
  task automatic long_character(input int rounds);
    int i;
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, coin(50));
    for (i = 0; i < rounds; i++) begin
      queue_sample(1'b1, 1'b1, 1'b0, 1'b0, coin(50));
      queue_sample(1'b0, coin(50), coin(50), 1'b1, coin(50));
      queue_sample(1'b1, 1'b0, 1'b0, 1'b0, coin(50));
      queue_sample(1'b0, coin(50), coin(50), 1'b1, coin(50));
    end
    queue_sample(1'b0, 1'b0, 1'b1, 1'b0, coin(50));
  endtask

  initial begin
    key_cfg       = '{dot_max: 16'd2, char_gap: 16'd10, word_gap: 16'd20};
    code_acc      = mkd_pkg::CODE_ONE;
    submit_streak = 2'd2;
    mark_total    = 8'd0;
    char_total    = 8'd0;
    last_keys     = 3'b111;
    held_ticks    = 16'd0;
    idle_ticks    = 16'd0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // three-button mode at reset settings
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // keys start as pressed: release
    queue_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // dot
    queue_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // dash
    queue_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // character
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // word gap
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // extra submit, silent
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);  // all rise together
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    wait_idle();

    // one-key mode with tight timing; an out-of-range index is ignored
    set_config(16'd1, 16'd1, 16'd3);
    write_reg(mkd_pkg::REG_UNUSED, 16'($urandom));
    queue_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);  // short hold: dot
    queue_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);  // long hold: dash
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);  // character gap
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);  // word gap
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);  // press with no tick keeps the gap
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);  // mark, character and word at once
    queue_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);  // back to three buttons: dash
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_idle();

    set_config(16'd2, 16'd10, 16'd20);
    random_traffic(40);
    wait_idle();

    set_config(16'd0, 16'd0, 16'd0);
    random_traffic(30);
    wait_idle();

    set_config(16'd3, 16'd5, 16'd5);
    random_traffic(30);
    wait_idle();

    // widest settings: gaps never expire, so one character can run long
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    long_character(52);
    wait_idle();

    set_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 6)));
    random_traffic(30);
    wait_idle();

    if (fail_count == 0)
      $display("morse_key_input_decoder_unit regression: pass");
    else
      $display("morse_key_input_decoder_unit regression: fail");
    $finish;
  end

endmodule

[morse_key_input_decoder_unit.f]
src/mkd_pkg.sv
src/mkd_cfg.sv
src/mkd_core.sv
src/mkd_evq.sv
src/morse_key_input_decoder_unit.sv
tb/tb_morse_key_input_decoder_unit.sv
